// ===== rtl/ilp_pkg.sv =====
// Shared types and constants of the INI line parser.
// No dependencies; imported by ilp_front, ilp_back and the top level.
`default_nettype none
package ilp_pkg;

	// Line kinds
	localparam logic [1:0] KIND_EMPTY   = 2'd0;
	localparam logic [1:0] KIND_SECTION = 2'd1;
	localparam logic [1:0] KIND_KEYVAL  = 2'd2;
	localparam logic [1:0] KIND_BAD     = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_END  = 2'd1;
	localparam logic [1:0] ERR_NAME = 2'd2;
	localparam logic [1:0] ERR_DATA = 2'd3;

	// Configuration register indexes
	localparam logic CFG_SPACE   = 1'b0;
	localparam logic CFG_COMMENT = 1'b1;

	// Reset values of the configuration registers
	localparam logic [31:0] SPACE_RESET   = 32'h0A0D_0920;
	localparam logic [31:0] COMMENT_RESET = 32'h0000_233B;

	// Fixed character codes
	localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
	localparam logic [7:0] CH_RBR   = 8'h5D;  // ']'
	localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
	localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
	localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'

	// Classified input item, front to back
	typedef struct packed {
		logic line_end;
		logic is_ws;
		logic is_eod;
		logic is_name;
		logic is_lbr;
		logic is_rbr;
		logic is_eq;
	} chr_class_t;

	// One line result
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  error_code;
		logic [7:0]  error_column;
		logic [31:0] line_number;
		logic [7:0]  name_start;
		logic [7:0]  name_end;
		logic [7:0]  value_start;
		logic [7:0]  value_end;
	} line_res_t;

endpackage
`default_nettype wire

// ===== rtl/ilp_fifo.sv =====
// Small flop-based queue used between the parser stages and at the output.
// No package dependency; width and depth are parameters.
`default_nettype none
module ilp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output logic [WIDTH-1:0]      rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			if (do_pop)  rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ilp_front.sv =====
// Front end: configuration registers and character classification.
// Depends on ilp_pkg.
`default_nettype none
module ilp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic [7:0]         ch,
	input  wire logic               line_end,
	output ilp_pkg::chr_class_t     cls
);
	import ilp_pkg::*;

	logic [31:0] space_q, comment_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q   <= SPACE_RESET;
			comment_q <= COMMENT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SPACE:   space_q   <= cfg_data;
				CFG_COMMENT: comment_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Set membership: a zero byte never matches
	function automatic logic in_set(input logic [31:0] set, input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (set[8*i +: 8] != 8'd0 && set[8*i +: 8] == c) hit = 1'b1;
		end
		return hit;
	endfunction

	// Classification
	always_comb begin
		cls.line_end = line_end;
		cls.is_ws    = in_set(space_q, ch);
		cls.is_eod   = (ch == 8'd0) || in_set(comment_q, ch);
		cls.is_name  = (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
		               (ch >= "a" && ch <= "z") || ch == CH_DOT || ch == CH_UNDER;
		cls.is_lbr   = (ch == CH_LBR);
		cls.is_rbr   = (ch == CH_RBR);
		cls.is_eq    = (ch == CH_EQ);
	end
endmodule
`default_nettype wire

// ===== rtl/ilp_back.sv =====
// Back end: line phase machine, column tracking and result assembly.
// Depends on ilp_pkg.
`default_nettype none
module ilp_back #(
	parameter int LINE_CHARS = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cls_avail,
	input  wire ilp_pkg::chr_class_t cls,
	output logic                     cls_pop,
	input  wire logic                res_full,
	output logic                     res_push,
	output ilp_pkg::line_res_t       res
);
	import ilp_pkg::*;

	localparam logic [7:0] COL_MAX = (LINE_CHARS - 1 > 255) ? 8'd255 : 8'(LINE_CHARS - 1);

	localparam logic [3:0] PH_LEAD     = 4'd0;
	localparam logic [3:0] PH_SEC_PRE  = 4'd1;
	localparam logic [3:0] PH_SEC_NAME = 4'd2;
	localparam logic [3:0] PH_SEC_GAP  = 4'd3;
	localparam logic [3:0] PH_SEC_POST = 4'd4;
	localparam logic [3:0] PH_KEY_NAME = 4'd5;
	localparam logic [3:0] PH_KEY_GAP  = 4'd6;
	localparam logic [3:0] PH_VAL_PRE  = 4'd7;
	localparam logic [3:0] PH_VAL      = 4'd8;
	localparam logic [3:0] PH_DONE     = 4'd9;

	logic [3:0]  phase_q, phase_d;
	logic [7:0]  col_q, col_nx;
	logic [31:0] lines_q, lines_nx;
	logic [1:0]  kind_q, kind_d, err_q, err_d;
	logic [7:0]  err_at_q, err_at_d;
	logic [7:0]  nb_q, nb_d, ns_q, ns_d, vb_q, vb_d, vs_q, vs_d;

	// Consume a character freely; a line end needs a result slot
	assign cls_pop  = cls_avail && (!cls.line_end || !res_full);
	assign res_push = cls_pop && cls.line_end;
	assign col_nx   = (col_q < COL_MAX) ? col_q + 8'd1 : COL_MAX;
	assign lines_nx = (lines_q == 32'hFFFF_FFFF) ? lines_q : lines_q + 32'd1;

	// Phase update for one character or line end
	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		err_d    = err_q;
		err_at_d = err_at_q;
		nb_d     = nb_q;
		ns_d     = ns_q;
		vb_d     = vb_q;
		vs_d     = vs_q;
		if (cls.line_end) begin
			unique case (phase_q)
				PH_LEAD, PH_SEC_POST, PH_VAL: begin
					err_at_d = col_q;
					phase_d  = PH_DONE;
				end
				PH_SEC_NAME, PH_KEY_NAME: begin
					ns_d     = col_q;
					err_d    = ERR_END;
					err_at_d = col_q;
					phase_d  = PH_DONE;
				end
				PH_SEC_PRE, PH_SEC_GAP, PH_KEY_GAP, PH_VAL_PRE: begin
					err_d    = ERR_END;
					err_at_d = col_q;
					phase_d  = PH_DONE;
				end
				default: ;
			endcase
		end else begin
			unique case (phase_q)
				PH_LEAD: begin
					priority if (cls.is_ws) begin
					end else if (cls.is_eod) begin
						err_at_d = col_q; phase_d = PH_DONE;
					end else if (cls.is_lbr) begin
						kind_d = KIND_SECTION; phase_d = PH_SEC_PRE;
					end else if (cls.is_name) begin
						kind_d = KIND_KEYVAL; nb_d = col_q; phase_d = PH_KEY_NAME;
					end else begin
						kind_d = KIND_BAD; err_d = ERR_NAME; err_at_d = col_q;
						phase_d = PH_DONE;
					end
				end
				PH_SEC_PRE: begin
					priority if (cls.is_ws) begin
					end else if (cls.is_eod) begin
						err_d = ERR_END; err_at_d = col_q; phase_d = PH_DONE;
					end else if (cls.is_name) begin
						nb_d = col_q; phase_d = PH_SEC_NAME;
					end else begin
						err_d = ERR_NAME; err_at_d = col_q; phase_d = PH_DONE;
					end
				end
				PH_SEC_NAME, PH_KEY_NAME: begin
					if (!cls.is_name) begin
						ns_d = col_q;
						priority if (cls.is_eod) begin
							err_d = ERR_END; err_at_d = col_q; phase_d = PH_DONE;
						end else if (phase_q == PH_SEC_NAME && cls.is_rbr) begin
							phase_d = PH_SEC_POST;
						end else if (phase_q == PH_KEY_NAME && cls.is_eq) begin
							phase_d = PH_VAL_PRE;
						end else if (cls.is_ws) begin
							phase_d = (phase_q == PH_SEC_NAME) ? PH_SEC_GAP : PH_KEY_GAP;
						end else begin
							err_d = ERR_NAME; err_at_d = col_q; phase_d = PH_DONE;
						end
					end
				end
				PH_SEC_GAP, PH_KEY_GAP: begin
					priority if (cls.is_ws) begin
					end else if (cls.is_eod) begin
						err_d = ERR_END; err_at_d = col_q; phase_d = PH_DONE;
					end else if (phase_q == PH_SEC_GAP && cls.is_rbr) begin
						phase_d = PH_SEC_POST;
					end else if (phase_q == PH_KEY_GAP && cls.is_eq) begin
						phase_d = PH_VAL_PRE;
					end else begin
						err_d = ERR_DATA; err_at_d = col_q; phase_d = PH_DONE;
					end
				end
				PH_SEC_POST: begin
					priority if (cls.is_ws) begin
					end else if (cls.is_eod) begin
						err_at_d = col_q; phase_d = PH_DONE;
					end else begin
						err_d = ERR_DATA; err_at_d = col_q; phase_d = PH_DONE;
					end
				end
				PH_VAL_PRE: begin
					priority if (cls.is_ws) begin
					end else if (cls.is_eod) begin
						err_d = ERR_END; err_at_d = col_q; phase_d = PH_DONE;
					end else begin
						vb_d = col_q; vs_d = col_nx; phase_d = PH_VAL;
					end
				end
				PH_VAL: begin
					priority if (cls.is_eod) begin
						err_at_d = col_q; phase_d = PH_DONE;
					end else if (!cls.is_ws) begin
						vs_d = col_nx;
					end else begin
					end
				end
				default: ;
			endcase
		end
	end

	// Result of the line being closed
	always_comb begin
		res.kind         = kind_d;
		res.error_code   = err_d;
		res.error_column = err_at_d;
		res.line_number  = lines_nx;
		res.name_start   = nb_d;
		res.name_end     = ns_d;
		res.value_start  = vb_d;
		res.value_end    = vs_d;
	end

	// Line state: cleared at every line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			col_q    <= '0;
			lines_q  <= '0;
			kind_q   <= KIND_EMPTY;
			err_q    <= ERR_NONE;
			err_at_q <= '0;
			nb_q     <= '0;
			ns_q     <= '0;
			vb_q     <= '0;
			vs_q     <= '0;
		end else if (cls_pop) begin
			if (cls.line_end) begin
				phase_q  <= PH_LEAD;
				col_q    <= '0;
				lines_q  <= lines_nx;
				kind_q   <= KIND_EMPTY;
				err_q    <= ERR_NONE;
				err_at_q <= '0;
				nb_q     <= '0;
				ns_q     <= '0;
				vb_q     <= '0;
				vs_q     <= '0;
			end else begin
				phase_q  <= phase_d;
				col_q    <= col_nx;
				kind_q   <= kind_d;
				err_q    <= err_d;
				err_at_q <= err_at_d;
				nb_q     <= nb_d;
				ns_q     <= ns_d;
				vb_q     <= vb_d;
				vs_q     <= vs_d;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ini_line_parser.sv =====
// INI line parser, top level.
// Depends on ilp_pkg, ilp_front, ilp_fifo and ilp_back.
//
// Usage:
//   Input channel (push/full): one transaction is one character (ch) or,
//   with line_end high, the end of the current line. A character is taken
//   every cycle while full is low.
//   Result channel (empty/pop): one result per line end: kind, first
//   error and its column, name span, trimmed value span and a saturating
//   line count. The oldest result is on the ports while empty is low.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the
//   whitespace codes, index 1 the comment codes; write only while idle.
// Throughput: one input transaction per cycle while the back end is not
//   holding a line end for a result slot; the phase update in the back end
//   is combinational. A line end passes through the registered classifier
//   queue, then goes straight into the registered result queue.
// Reset: all queues empty, line state cleared, line count zero and the
//   config registers back to space/tab/CR/LF and ';'/'#'.
// Stall: when results are not popped the result queue fills; the back end
//   still consumes characters but holds a line end, the classifier queue
//   fills and full rises until a result is taken.
`default_nettype none
module ini_line_parser #(
	parameter int LINE_CHARS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  ch,
	input  wire logic        line_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [1:0]       error_code,
	output logic [7:0]       error_column,
	output logic [31:0]      line_number,
	output logic [7:0]       name_start,
	output logic [7:0]       name_end,
	output logic [7:0]       value_start,
	output logic [7:0]       value_end
);
	import ilp_pkg::*;

	localparam int QDEPTH = 2;

	chr_class_t cls_in, cls_out;
	line_res_t  res_in, res_out;
	logic       cls_empty, cls_pop, res_full, res_push;

	assign cfg_ready = 1'b1;

	// Front: classify characters
	ilp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ch        (ch),
		.line_end  (line_end),
		.cls       (cls_in)
	);

	// Queue between front and back
	ilp_fifo #(.WIDTH($bits(chr_class_t)), .DEPTH(QDEPTH)) u_cls_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (full),
		.pop    (cls_pop),
		.empty  (cls_empty),
		.rdata  (cls_out)
	);

	// Back: phase machine
	ilp_back #(.LINE_CHARS(LINE_CHARS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_avail (!cls_empty),
		.cls       (cls_out),
		.cls_pop   (cls_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue
	ilp_fifo #(.WIDTH($bits(line_res_t)), .DEPTH(QDEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	assign kind         = res_out.kind;
	assign error_code   = res_out.error_code;
	assign error_column = res_out.error_column;
	assign line_number  = res_out.line_number;
	assign name_start   = res_out.name_start;
	assign name_end     = res_out.name_end;
	assign value_start  = res_out.value_start;
	assign value_end    = res_out.value_end;

	// Back end never pushes into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed while queue full");

	// A held line end must not be consumed
	a_line_end_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!cls_empty && cls_out.line_end && res_full) |-> !cls_pop)
		else $error("line end consumed without result slot");

	// Every delivered line has a nonzero count
	a_line_number_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> line_number != 32'd0)
		else $error("result with zero line number");

	// Section and empty lines never report a value span
	a_no_value_span: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == KIND_SECTION || kind == KIND_EMPTY)) |->
		(value_start == 8'd0 && value_end == 8'd0))
		else $error("value span on a line without value");
endmodule
`default_nettype wire
